// ===== design/wpd_pkg.sv =====
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants for the weighted pose distance block.
// ----------------------------------------------------------------------------
package wpd_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int CORDIC_STEPS = 30;

	localparam logic [CFG_IDX_W-1:0] REG_TRANS_WEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_WEIGHT   = 1'd1;

	localparam logic [15:0] TRANS_WEIGHT_RST = 16'd32768;
	localparam logic [15:0] ROT_WEIGHT_RST   = 16'd45875;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQ,
		ST_PROD,
		ST_CLAMP,
		ST_CSQ,
		ST_SQRT,
		ST_CORDIC,
		ST_WEIGHT,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                    req_type;
		logic [COORD_WIDTH-1:0]  a_comp0;
		logic [COORD_WIDTH-1:0]  a_comp1;
		logic [COORD_WIDTH-1:0]  a_comp2;
		logic [COORD_WIDTH-1:0]  a_comp3;
		logic [COORD_WIDTH-1:0]  b_comp0;
		logic [COORD_WIDTH-1:0]  b_comp1;
		logic [COORD_WIDTH-1:0]  b_comp2;
		logic [COORD_WIDTH-1:0]  b_comp3;
		logic                    last_body;
	} req_t;

	typedef struct packed {
		logic [31:0] total_distance;
		logic        overflowed;
	} rsp_t;

	// atan(2^-i) in Q.30; exact power of two beyond the table
	function automatic logic [31:0] atan_step(input logic [4:0] i);
		case (i)
			5'd0: atan_step = 32'd843314857;
			5'd1: atan_step = 32'd497837829;
			5'd2: atan_step = 32'd263043837;
			5'd3: atan_step = 32'd133525159;
			5'd4: atan_step = 32'd67021687;
			5'd5: atan_step = 32'd33543516;
			5'd6: atan_step = 32'd16775851;
			5'd7: atan_step = 32'd8388437;
			5'd8: atan_step = 32'd4194283;
			5'd9: atan_step = 32'd2097149;
			default: atan_step = 32'd1 << (5'd30 - i);
		endcase
	endfunction

endpackage

// ===== design/wpd_if.sv =====
// ----------------------------------------------------------------------------
// wpd_req_if / wpd_rsp_if
// Valid/ready channels for request and result items.
// ----------------------------------------------------------------------------
interface wpd_req_if import wpd_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface wpd_rsp_if import wpd_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/weighted_pose_distance.sv =====
// ----------------------------------------------------------------------------
// weighted_pose_distance
// Accumulates weighted translation and rotation distances per body pair.
// ----------------------------------------------------------------------------
// channel | dir | carries
// req     | in  | req_type, a_comp0..3, b_comp0..3, last_body
// rsp     | out | total_distance, overflowed (only on last_body items)
// cfg     | in  | trans_weight (0), rot_weight (1)
//
// Position and rotation items share one multiplier and a one-bit-per-cycle
// square root (34 steps); rotations add 30 CORDIC steps. An item marked last
// then loads the output register, and holds there while an earlier result
// is still unaccepted. req.ready is high only in idle. Reset clears sum, flag
// and result valid.
// ----------------------------------------------------------------------------
module weighted_pose_distance import wpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	wpd_req_if.sink               req,
	wpd_rsp_if.source             rsp
);

	state_t state_q, state_d;

	logic [15:0] trans_w_q, rot_w_q;
	logic [31:0] sum_q;
	logic        sat_q;
	logic        last_q, type_q;

	logic signed [COORD_WIDTH-1:0] a_q [4];
	logic signed [COORD_WIDTH-1:0] b_q [4];
	logic signed [COORD_WIDTH:0]   d_q [3];
	logic [1:0]  k_q;
	logic [5:0]  cnt_q;

	logic [67:0] acc_q;      // sum of squares, or dot product (signed)
	logic [67:0] rem_q;
	logic [67:0] rad_q;      // radicand for sqrt
	logic [33:0] root_q;
	logic signed [33:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [33:0] term_q;
	rsp_t        out_q;
	logic        out_v_q;

	// shared multiplier
	logic signed [34:0] mul_a, mul_b;
	logic signed [69:0] mul_p;
	assign mul_p = mul_a * mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ: begin
				mul_a = 35'(d_q[k_q]);
				mul_b = 35'(d_q[k_q]);
			end
			ST_PROD: begin
				mul_a = 35'(a_q[k_q]);
				mul_b = 35'(b_q[k_q]);
			end
			ST_CSQ: begin
				mul_a = 35'(acc_q[30:0]);
				mul_b = 35'(acc_q[30:0]);
			end
			ST_WEIGHT: begin
				mul_a = {1'b0, root_q};
				mul_b = type_q ? {19'd0, rot_w_q} : {19'd0, trans_w_q};
			end
			default: ;
		endcase
	end

	// sqrt step
	logic [67:0] rem_sh, trial;
	assign rem_sh = {rem_q[65:0], rad_q[67:66]};
	assign trial  = {32'd0, root_q, 2'b01};

	// cordic step
	logic signed [33:0] xs, ys;
	assign xs = x_q >>> cnt_q[4:0];
	assign ys = y_q >>> cnt_q[4:0];

	logic signed [33:0] atan_s, z_nx;
	assign atan_s = $signed({2'b00, atan_step(cnt_q[4:0])});
	assign z_nx   = (y_q > 0) ? z_q + atan_s : z_q - atan_s;

	logic [34:0] sum_ext;
	assign sum_ext = {3'd0, sum_q} + {1'b0, term_q};

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (req.valid && req.ready) state_d = ST_DIFF;
			ST_DIFF:   state_d = type_q ? ST_PROD : ST_SQ;
			ST_SQ:     if (k_q == 2'd2) state_d = ST_SQRT;
			ST_PROD:   if (k_q == 2'd3) state_d = ST_CLAMP;
			ST_CLAMP:  state_d = ST_CSQ;
			ST_CSQ:    state_d = ST_SQRT;
			ST_SQRT:   if (cnt_q == 6'd33) state_d = type_q ? ST_CORDIC : ST_WEIGHT;
			ST_CORDIC: if (cnt_q == 6'(CORDIC_STEPS - 1)) state_d = ST_WEIGHT;
			ST_WEIGHT: state_d = ST_ACC;
			ST_ACC:    state_d = last_q ? ST_OUT : ST_IDLE;
			ST_OUT:    if (!out_v_q) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			trans_w_q <= TRANS_WEIGHT_RST;
			rot_w_q   <= ROT_WEIGHT_RST;
			sum_q     <= '0;
			sat_q     <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_idx == REG_TRANS_WEIGHT) trans_w_q <= cfg_data;
			if (cfg_we && cfg_idx == REG_ROT_WEIGHT)   rot_w_q   <= cfg_data;
			if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			if (state_q == ST_ACC) begin
				if (sum_ext[34:32] != 3'd0) begin
					sum_q <= '1;
					sat_q <= 1'b1;
				end else begin
					sum_q <= sum_ext[31:0];
				end
			end
			if (state_q == ST_OUT && !out_v_q) begin
				out_v_q <= 1'b1;
				sum_q   <= '0;
				sat_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				type_q <= req.data.req_type;
				last_q <= req.data.last_body;
				a_q[0] <= req.data.a_comp0; a_q[1] <= req.data.a_comp1;
				a_q[2] <= req.data.a_comp2; a_q[3] <= req.data.a_comp3;
				b_q[0] <= req.data.b_comp0; b_q[1] <= req.data.b_comp1;
				b_q[2] <= req.data.b_comp2; b_q[3] <= req.data.b_comp3;
				k_q    <= '0;
				cnt_q  <= '0;
				acc_q  <= '0;
				rem_q  <= '0;
				root_q <= '0;
				z_q    <= '0;
			end
			ST_DIFF: begin
				for (int i = 0; i < 3; i++)
					d_q[i] <= (COORD_WIDTH+1)'(a_q[i]) - (COORD_WIDTH+1)'(b_q[i]);
			end
			ST_SQ: begin
				acc_q <= acc_q + 68'(mul_p[67:0]);
				k_q   <= k_q + 2'd1;
				rad_q <= acc_q + 68'(mul_p[67:0]);
			end
			ST_PROD: begin
				acc_q <= acc_q + 68'(mul_p >>> 2);
				k_q   <= k_q + 2'd1;
			end
			ST_CLAMP: begin
				// |dot| clamped to 1.0 in Q.30
				if ($signed(acc_q) < 0) begin
					if ($signed(acc_q) < -$signed(68'd1 << 30)) acc_q <= 68'd1 << 30;
					else acc_q <= 68'(-$signed(acc_q));
				end else if (acc_q > (68'd1 << 30)) begin
					acc_q <= 68'd1 << 30;
				end
			end
			ST_CSQ: begin
				rad_q <= (68'd1 << 60) - 68'(mul_p[61:0]);
				x_q   <= 34'(acc_q[30:0]);
			end
			ST_SQRT: begin
				rad_q <= {rad_q[65:0], 2'b00};
				cnt_q <= (cnt_q == 6'd33) ? 6'd0 : cnt_q + 6'd1;
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[32:0], 1'b1};
					if (cnt_q == 6'd33) y_q <= $signed({root_q[32:0], 1'b1});
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[32:0], 1'b0};
					if (cnt_q == 6'd33) y_q <= $signed({root_q[32:0], 1'b0});
				end
			end
			ST_CORDIC: begin
				cnt_q <= cnt_q + 6'd1;
				z_q   <= z_nx;
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
				end
				// angle in Q.16 feeds the weight multiply
				if (cnt_q == 6'(CORDIC_STEPS - 1))
					root_q <= z_nx[33] ? '0 : 34'(z_nx[33:14]);
			end
			ST_WEIGHT: begin
				term_q <= 34'(mul_p[49:16]);
			end
			ST_OUT: begin
				if (!out_v_q) begin
					out_q.total_distance <= sum_q;
					out_q.overflowed     <= sat_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== design/wpd_checker.sv =====
// ----------------------------------------------------------------------------
// wpd_checker
// Port-level checks for weighted_pose_distance.
// ----------------------------------------------------------------------------
module wpd_checker import wpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result dropped or changed under stall");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("accepted item while busy");

	a_handshake_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(req_ready) && !$isunknown(rsp_valid))
		else $error("handshake output unknown");

	// a saturated sum stays pinned at full scale
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.overflowed |-> rsp_data.total_distance == '1)
		else $error("overflow flagged without full-scale total");

endmodule

bind weighted_pose_distance wpd_checker u_wpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
